// File: rtl/ils_pkg.sv
// Shared types and constants for the indexed list store.
// Holds the request and result structs, the request and status codes
// and the control structs between the top level and the cells.
package ils_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 7;
	localparam int COUNT_W  = 7;
	localparam int DATA_W   = 32;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int GROUP    = 8;
	localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

	typedef enum logic [2:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_INSERT     = 3'd2,
		REQ_REMOVE     = 3'd3,
		REQ_READ       = 3'd4,
		REQ_CLEAR      = 3'd5
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		req_type_t                req_type;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [COUNT_W-1:0]       count;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] back_value;
		status_t                  status;
	} rsp_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2
	} cell_mode_t;

	// Shift command broadcast to every cell.
	typedef struct packed {
		cell_mode_t         mode;
		logic [IDX_W-1:0]   pos;
		logic [DATA_W-1:0]  value;
	} cell_ctrl_t;

	// Read-out taps: each cell drives its word onto a tap when its index matches.
	typedef struct packed {
		logic               rd_en;
		logic [IDX_W-1:0]   rd_pos;
		logic               bk_en;
		logic [IDX_W-1:0]   bk_pos;
	} tap_ctrl_t;

endpackage

// File: rtl/ils_cell.sv
// One storage cell of the list row: holds one entry and trades it with
// its neighbors on insert and remove. Depends on ils_pkg.
module ils_cell (
	input  logic                      clk,
	input  logic [ils_pkg::IDX_W-1:0]  idx,
	input  ils_pkg::cell_ctrl_t        ctrl,
	input  ils_pkg::tap_ctrl_t         tap,
	input  logic [ils_pkg::DATA_W-1:0] left_val,
	input  logic [ils_pkg::DATA_W-1:0] right_val,
	output logic [ils_pkg::DATA_W-1:0] val,
	output logic [ils_pkg::DATA_W-1:0] rd_tap,
	output logic [ils_pkg::DATA_W-1:0] bk_tap
);
	import ils_pkg::*;

	logic [DATA_W-1:0] val_q;

	always_ff @(posedge clk) begin
		case (ctrl.mode)
			CELL_INSERT: begin
				if (idx > ctrl.pos) begin
					val_q <= left_val;
				end else if (idx == ctrl.pos) begin
					val_q <= ctrl.value;
				end
			end
			CELL_REMOVE: begin
				if (idx >= ctrl.pos) begin
					val_q <= right_val;
				end
			end
			default: begin
			end
		endcase
	end

	assign val    = val_q;
	assign rd_tap = (tap.rd_en && idx == tap.rd_pos) ? val_q : '0;
	assign bk_tap = (tap.bk_en && idx == tap.bk_pos) ? val_q : '0;

endmodule

// File: rtl/ils_tree.sv
// Two-level OR tree that collects the one-hot read and back taps of the cell row.
// The first level is registered per group of cells. Depends on ils_pkg.
module ils_tree (
	input  logic                      clk,
	input  logic [ils_pkg::DATA_W-1:0] rd_tap [ils_pkg::CAPACITY],
	input  logic [ils_pkg::DATA_W-1:0] bk_tap [ils_pkg::CAPACITY],
	output logic [ils_pkg::DATA_W-1:0] rd_word,
	output logic [ils_pkg::DATA_W-1:0] bk_word
);
	import ils_pkg::*;

	logic [DATA_W-1:0] grp_rd_s2 [NGROUP];
	logic [DATA_W-1:0] grp_bk_s2 [NGROUP];

	always_ff @(posedge clk) begin
		for (int g = 0; g < NGROUP; g++) begin
			logic [DATA_W-1:0] acc_rd;
			logic [DATA_W-1:0] acc_bk;
			acc_rd = '0;
			acc_bk = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < CAPACITY) begin
					acc_rd = acc_rd | rd_tap[g * GROUP + k];
					acc_bk = acc_bk | bk_tap[g * GROUP + k];
				end
			end
			grp_rd_s2[g] <= acc_rd;
			grp_bk_s2[g] <= acc_bk;
		end
	end

	always_comb begin
		rd_word = '0;
		bk_word = '0;
		for (int g = 0; g < NGROUP; g++) begin
			rd_word = rd_word | grp_rd_s2[g];
			bk_word = bk_word | grp_bk_s2[g];
		end
	end

endmodule

// File: rtl/indexed_list_store.sv
// Bounded ordered list of signed 32-bit words kept in a row of shifting cells,
// built from ils_cell and ils_tree, with types from ils_pkg.
//
// A request is taken at a rising edge where start is high and busy is low. The cell
// row shifts at that edge. Busy is high for the following cycle while the row is tapped
// into the registered OR tree. The result is driven on rsp with done high for one cycle
// that starts once the tree's group registers and then the rsp and done registers are loaded.
// The next request can be accepted once busy falls, while the last result is still in the
// tree and output registers; the busy cycle over the tap stage holds it off. The receiver
// cannot stall; done marks every result exactly once.
module indexed_list_store (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ils_pkg::req_t req,
	output logic          done,
	output ils_pkg::rsp_t rsp
);
	import ils_pkg::*;

	logic              accept;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	cell_ctrl_t        cell_ctrl;
	cell_mode_t        mode_nxt;
	logic [IDX_W-1:0]  pos_nxt;
	status_t           status_nxt;
	logic              rd_en_nxt;
	logic [CMP_W-1:0]  pos_cmp;
	logic [CMP_W-1:0]  cnt_cmp;
	logic              full;

	logic              v_s1;
	status_t           status_s1;
	logic              rd_en_s1;
	logic [IDX_W-1:0]  rd_pos_s1;
	tap_ctrl_t         tap_ctrl;

	logic              v_s2;
	status_t           status_s2;
	logic [CNT_W-1:0]  count_s2;
	logic [DATA_W-1:0] front_s2;

	logic [DATA_W-1:0] cell_val [CAPACITY];
	logic [DATA_W-1:0] rd_tap   [CAPACITY];
	logic [DATA_W-1:0] bk_tap   [CAPACITY];
	logic [DATA_W-1:0] rd_word;
	logic [DATA_W-1:0] bk_word;

	logic              done_q;
	rsp_t              rsp_q;

	assign accept  = start && !busy;
	assign busy    = v_s1;
	assign pos_cmp = CMP_W'(req.position);
	assign cnt_cmp = CMP_W'(count_q);
	assign full    = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		mode_nxt   = CELL_HOLD;
		pos_nxt    = IDX_W'(req.position);
		status_nxt = ST_OK;
		rd_en_nxt  = 1'b0;
		count_nxt  = count_q;
		unique case (req.req_type)
			REQ_PUSH_FRONT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					mode_nxt  = CELL_INSERT;
					pos_nxt   = '0;
					count_nxt = count_q + 1'b1;
				end
			end
			REQ_PUSH_BACK: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					mode_nxt  = CELL_INSERT;
					pos_nxt   = IDX_W'(count_q);
					count_nxt = count_q + 1'b1;
				end
			end
			REQ_INSERT: begin
				if (pos_cmp > cnt_cmp) begin
					status_nxt = ST_RANGE;
				end else if (full) begin
					status_nxt = ST_FULL;
				end else begin
					mode_nxt  = CELL_INSERT;
					count_nxt = count_q + 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (pos_cmp >= cnt_cmp) begin
					status_nxt = ST_RANGE;
				end else begin
					mode_nxt  = CELL_REMOVE;
					count_nxt = count_q - 1'b1;
				end
			end
			REQ_READ: begin
				if (pos_cmp >= cnt_cmp) begin
					status_nxt = ST_RANGE;
				end else begin
					rd_en_nxt = 1'b1;
				end
			end
			REQ_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cell_ctrl.mode  = accept ? mode_nxt : CELL_HOLD;
		cell_ctrl.pos   = pos_nxt;
		cell_ctrl.value = req.item_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			v_s1   <= accept;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_nxt;
			rd_en_s1  <= rd_en_nxt;
			rd_pos_s1 <= pos_nxt;
		end
		status_s2 <= status_s1;
		count_s2  <= count_q;
		front_s2  <= (count_q != '0) ? cell_val[0] : '0;
		rsp_q.read_value  <= rd_word;
		rsp_q.count       <= COUNT_W'(count_s2);
		rsp_q.front_value <= front_s2;
		rsp_q.back_value  <= bk_word;
		rsp_q.status      <= status_s2;
	end

	// The list only changes at accept, so the row is tapped after the shift.
	always_comb begin
		tap_ctrl.rd_en  = rd_en_s1;
		tap_ctrl.rd_pos = rd_pos_s1;
		tap_ctrl.bk_en  = (count_q != '0);
		tap_ctrl.bk_pos = IDX_W'(count_q - 1'b1);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_val;
		logic [DATA_W-1:0] right_val;
		if (i == 0) begin : g_first
			assign left_val = cell_val[i];
		end else begin : g_mid_l
			assign left_val = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_val = cell_val[i];
		end else begin : g_mid_r
			assign right_val = cell_val[i+1];
		end
		ils_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(i)),
			.ctrl      (cell_ctrl),
			.tap       (tap_ctrl),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (cell_val[i]),
			.rd_tap    (rd_tap[i]),
			.bk_tap    (bk_tap[i])
		);
	end

	ils_tree u_tree (
		.clk     (clk),
		.rd_tap  (rd_tap),
		.bk_tap  (bk_tap),
		.rd_word (rd_word),
		.bk_word (bk_word)
	);

	assign done = done_q;
	assign rsp  = rsp_q;

	// Every result must trace back to the edge that accepted its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 3))
	else $error("result without a matching request");

	// The row never holds more entries than cells.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
	else $error("entry count beyond capacity");

	// Busy lasts one cycle per request, so back-to-back accepts are impossible.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy ##1 !busy)
	else $error("busy window is not one cycle");

	// The count only moves on an accepted request.
	assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
	else $error("count changed without a request");

endmodule
